@@ hdl/uvs_pkg.sv @@
// Shared constants, types and arithmetic helpers for the UV-sphere vertex generator.
package uvs_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int MAX_RINGS    = 256;
    localparam int MIN_SEGMENTS = 3;
    localparam int MIN_RINGS    = 2;
    localparam int COUNT_W      = 9;
    localparam int TEX_BITS     = 16;
    localparam int TEX_W        = TEX_BITS + 1;
    localparam int POS_W        = 17;
    localparam int NORM_W       = 16;
    localparam int RADIUS_W     = 16;

    localparam int TURN_BITS    = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int CORDIC_K     = 652032874;
    localparam int Q14_ONE      = 16384;
    localparam int CX_W         = 34;
    localparam int CZ_W         = 25;
    localparam int WIDE_W       = 40;

    localparam int DIV_W        = 36;
    localparam int DIV_BITS     = 4;
    localparam int DIV_STAGES   = DIV_W / DIV_BITS;
    localparam int DIV_LANES    = 4;
    localparam int LANE_THETA   = 0;
    localparam int LANE_TEX_U   = 1;
    localparam int LANE_PHI     = 2;
    localparam int LANE_TEX_V   = 3;

    typedef enum logic [1:0] {
        REG_RADIUS   = 2'd0,
        REG_SEGMENTS = 2'd1,
        REG_RINGS    = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [COUNT_W-1:0] rem;
        logic [DIV_W-1:0]   num;
        logic [DIV_W-1:0]   quo;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [DIV_LANES-1:0] lane;
        logic                      oor;
    } t_div;

    typedef struct packed {
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        logic             oor;
    } t_side;

    typedef struct packed {
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
        logic signed [CZ_W-1:0] z;
        logic [1:0]             quad;
        logic                   zero;
    } t_cordic;

    function automatic logic signed [CZ_W-1:0] atan_turn(input int idx);
        logic signed [CZ_W-1:0] a;
        case (idx)
            0:       a = CZ_W'(2097152);
            1:       a = CZ_W'(1238021);
            2:       a = CZ_W'(654136);
            3:       a = CZ_W'(332050);
            4:       a = CZ_W'(166669);
            5:       a = CZ_W'(83416);
            6:       a = CZ_W'(41718);
            7:       a = CZ_W'(20860);
            8:       a = CZ_W'(10430);
            9:       a = CZ_W'(5215);
            10:      a = CZ_W'(2608);
            11:      a = CZ_W'(1304);
            12:      a = CZ_W'(652);
            13:      a = CZ_W'(326);
            14:      a = CZ_W'(163);
            15:      a = CZ_W'(81);
            default: a = '0;
        endcase
        return a;
    endfunction

    // round half away from zero, then shift right by s
    function automatic logic signed [WIDE_W-1:0] rnd_shr(input logic signed [WIDE_W-1:0] v,
                                                         input int s);
        logic signed [WIDE_W-1:0] h;
        logic signed [WIDE_W-1:0] r;
        h = WIDE_W'(1) <<< (s - 1);
        if (v >= 0) begin
            r = (v + h) >>> s;
        end else begin
            r = -((-v + h) >>> s);
        end
        return r;
    endfunction

    function automatic logic signed [NORM_W-1:0] sat_q14(input logic signed [WIDE_W-1:0] v);
        logic signed [NORM_W-1:0] r;
        if (v > WIDE_W'(Q14_ONE)) begin
            r = NORM_W'(Q14_ONE);
        end else if (v < -WIDE_W'(Q14_ONE)) begin
            r = -NORM_W'(Q14_ONE);
        end else begin
            r = v[NORM_W-1:0];
        end
        return r;
    endfunction

    // DIV_BITS steps of restoring long division
    function automatic t_div_lane div_stage(input t_div_lane a, input logic [COUNT_W-1:0] d);
        t_div_lane        r;
        logic [COUNT_W:0] t;
        r = a;
        for (int b = 0; b < DIV_BITS; b++) begin
            t     = {r.rem, r.num[DIV_W-1]};
            r.num = {r.num[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, d}) begin
                t     = t - {1'b0, d};
                r.quo = {r.quo[DIV_W-2:0], 1'b1};
            end else begin
                r.quo = {r.quo[DIV_W-2:0], 1'b0};
            end
            r.rem = t[COUNT_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/uvs_cordic.sv @@
// Pipelined rotation-mode CORDIC giving Q1.14 cosine and sine of a turn-unit angle.
module uvs_cordic import uvs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [TURN_BITS-1:0]     i_angle,
    output logic signed [NORM_W-1:0] o_cos,
    output logic signed [NORM_W-1:0] o_sin
);

    t_cordic                  r_st [0:CORDIC_STEPS];
    logic signed [NORM_W-1:0] r_cos;
    logic signed [NORM_W-1:0] r_sin;
    logic signed [NORM_W-1:0] n_cos;
    logic signed [NORM_W-1:0] n_sin;
    logic signed [NORM_W-1:0] cr;
    logic signed [NORM_W-1:0] sr;

    function automatic t_cordic cordic_step(input t_cordic a, input int i);
        t_cordic                r;
        logic signed [CX_W-1:0] dx;
        logic signed [CX_W-1:0] dy;
        r  = a;
        dx = a.y >>> i;
        dy = a.x >>> i;
        if (a.z >= 0) begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - atan_turn(i);
        end else begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + atan_turn(i);
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].x    <= CX_W'(CORDIC_K);
            r_st[0].y    <= '0;
            r_st[0].z    <= CZ_W'(i_angle[TURN_BITS-3:0]);
            r_st[0].quad <= i_angle[TURN_BITS-1 -: 2];
            r_st[0].zero <= (i_angle[TURN_BITS-3:0] == '0);
            for (int k = 0; k < CORDIC_STEPS; k++) begin
                r_st[k+1] <= cordic_step(r_st[k], k);
            end
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    always_comb begin
        if (r_st[CORDIC_STEPS].zero) begin
            cr = NORM_W'(Q14_ONE);
            sr = '0;
        end else begin
            cr = sat_q14(rnd_shr(WIDE_W'(r_st[CORDIC_STEPS].x), 16));
            sr = sat_q14(rnd_shr(WIDE_W'(r_st[CORDIC_STEPS].y), 16));
        end
        case (r_st[CORDIC_STEPS].quad)
            2'd0: begin
                n_cos = cr;
                n_sin = sr;
            end
            2'd1: begin
                n_cos = -sr;
                n_sin = cr;
            end
            2'd2: begin
                n_cos = -cr;
                n_sin = -sr;
            end
            default: begin
                n_cos = sr;
                n_sin = -cr;
            end
        endcase
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

@@ hdl/uv_sphere_vertex_gen.sv @@
// UV-sphere vertex generator: throughput one beat per cycle unless the pipeline holds.
// 9 long-division stages, 18 CORDIC stages, 2 multiplies.
// The whole pipeline advances together and holds while the output beat is not taken.
// Synchronous active-low reset clears the valid bits and loads radius 256,
// 16 segments and 8 rings.
module uv_sphere_vertex_gen import uvs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [COUNT_W-1:0]       i_ring_index,
    input  logic [COUNT_W-1:0]       i_segment_index,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [POS_W-1:0]  o_pos_x,
    output logic signed [POS_W-1:0]  o_pos_y,
    output logic signed [POS_W-1:0]  o_pos_z,
    output logic signed [NORM_W-1:0] o_norm_x,
    output logic signed [NORM_W-1:0] o_norm_y,
    output logic signed [NORM_W-1:0] o_norm_z,
    output logic [TEX_W-1:0]         o_tex_u,
    output logic [TEX_W-1:0]         o_tex_v,
    output logic                     o_out_of_range
);

    logic [RADIUS_W-1:0] r_radius;
    logic [COUNT_W-1:0]  r_seg_count;
    logic [COUNT_W-1:0]  r_ring_count;
    logic [COUNT_W-1:0]  wr_val;
    logic                cfg_wr;

    logic en;
    logic accept;

    t_div r_dv       [0:DIV_STAGES];
    logic r_dv_valid [0:DIV_STAGES];
    t_div n_dv0;

    t_side r_sd [0:CORDIC_LAT-1];
    logic  r_sv [0:CORDIC_LAT-1];
    t_side n_sd0;

    logic signed [NORM_W-1:0] cos_t;
    logic signed [NORM_W-1:0] sin_t;
    logic signed [NORM_W-1:0] cos_p;
    logic signed [NORM_W-1:0] sin_p;

    logic                       r_m1_valid;
    logic signed [2*NORM_W-1:0] r_m1_px;
    logic signed [2*NORM_W-1:0] r_m1_pz;
    logic signed [NORM_W-1:0]   r_m1_ny;
    t_side                      r_m1_sd;

    logic                     r_m2_valid;
    logic signed [NORM_W-1:0] r_m2_nx;
    logic signed [NORM_W-1:0] r_m2_ny;
    logic signed [NORM_W-1:0] r_m2_nz;
    t_side                    r_m2_sd;

    logic                     r_m3_valid;
    logic signed [NORM_W+RADIUS_W:0] r_m3_qx;
    logic signed [NORM_W+RADIUS_W:0] r_m3_qy;
    logic signed [NORM_W+RADIUS_W:0] r_m3_qz;
    logic signed [NORM_W-1:0] r_m3_nx;
    logic signed [NORM_W-1:0] r_m3_ny;
    logic signed [NORM_W-1:0] r_m3_nz;
    t_side                    r_m3_sd;
    logic signed [RADIUS_W:0] rad_s;

    logic                     r_out_valid;
    logic signed [POS_W-1:0]  r_pos_x;
    logic signed [POS_W-1:0]  r_pos_y;
    logic signed [POS_W-1:0]  r_pos_z;
    logic signed [NORM_W-1:0] r_norm_x;
    logic signed [NORM_W-1:0] r_norm_y;
    logic signed [NORM_W-1:0] r_norm_z;
    logic [TEX_W-1:0]         r_tex_u;
    logic [TEX_W-1:0]         r_tex_v;
    logic                     r_oor;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign wr_val = pwdata[COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= RADIUS_W'(256);
            r_seg_count  <= COUNT_W'(16);
            r_ring_count <= COUNT_W'(8);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_RADIUS: begin
                    r_radius <= pwdata[RADIUS_W-1:0];
                end
                REG_SEGMENTS: begin
                    if (wr_val < COUNT_W'(MIN_SEGMENTS)) begin
                        r_seg_count <= COUNT_W'(MIN_SEGMENTS);
                    end else if (wr_val > COUNT_W'(MAX_SEGMENTS)) begin
                        r_seg_count <= COUNT_W'(MAX_SEGMENTS);
                    end else begin
                        r_seg_count <= wr_val;
                    end
                end
                REG_RINGS: begin
                    if (wr_val < COUNT_W'(MIN_RINGS)) begin
                        r_ring_count <= COUNT_W'(MIN_RINGS);
                    end else if (wr_val > COUNT_W'(MAX_RINGS)) begin
                        r_ring_count <= COUNT_W'(MAX_RINGS);
                    end else begin
                        r_ring_count <= wr_val;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_RADIUS:   prdata = 32'(r_radius);
            REG_SEGMENTS: prdata = 32'(r_seg_count);
            REG_RINGS:    prdata = 32'(r_ring_count);
            default:      prdata = '0;
        endcase
    end

    // pipeline control
    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign accept     = i_in_valid && en;

    always_comb begin
        n_dv0     = '0;
        n_dv0.oor = (i_ring_index > r_ring_count) || (i_segment_index > r_seg_count);
        n_dv0.lane[LANE_THETA].num = (DIV_W'(i_segment_index) << TURN_BITS)
                                   + DIV_W'(r_seg_count >> 1);
        n_dv0.lane[LANE_TEX_U].num = (DIV_W'(i_segment_index) << TEX_BITS)
                                   + DIV_W'(r_seg_count >> 1);
        n_dv0.lane[LANE_PHI].num   = (DIV_W'(i_ring_index) << (TURN_BITS - 1))
                                   + DIV_W'(r_ring_count >> 1);
        n_dv0.lane[LANE_TEX_V].num = (DIV_W'(i_ring_index) << TEX_BITS)
                                   + DIV_W'(r_ring_count >> 1);
    end

    always_comb begin
        n_sd0.tex_u = r_dv[DIV_STAGES].lane[LANE_TEX_U].quo[TEX_W-1:0];
        n_sd0.tex_v = TEX_W'(1 << TEX_BITS)
                    - r_dv[DIV_STAGES].lane[LANE_TEX_V].quo[TEX_W-1:0];
        n_sd0.oor   = r_dv[DIV_STAGES].oor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                r_dv_valid[s] <= 1'b0;
            end
            for (int s = 0; s < CORDIC_LAT; s++) begin
                r_sv[s] <= 1'b0;
            end
            r_m1_valid  <= 1'b0;
            r_m2_valid  <= 1'b0;
            r_m3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_dv_valid[0] <= accept;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_dv_valid[s+1] <= r_dv_valid[s];
            end
            r_sv[0] <= r_dv_valid[DIV_STAGES];
            for (int s = 0; s < CORDIC_LAT - 1; s++) begin
                r_sv[s+1] <= r_sv[s];
            end
            r_m1_valid  <= r_sv[CORDIC_LAT-1];
            r_m2_valid  <= r_m1_valid;
            r_m3_valid  <= r_m2_valid;
            r_out_valid <= r_m3_valid;
        end
    end

    // long division: theta, tex u, phi, tex v
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= n_dv0;
            for (int s = 0; s < DIV_STAGES; s++) begin
                r_dv[s+1].oor <= r_dv[s].oor;
                for (int l = 0; l < DIV_LANES; l++) begin
                    r_dv[s+1].lane[l] <= div_stage(r_dv[s].lane[l],
                        (l < LANE_PHI) ? r_seg_count : r_ring_count);
                end
            end
        end
    end

    uvs_cordic u_cordic_theta (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_dv[DIV_STAGES].lane[LANE_THETA].quo[TURN_BITS-1:0]),
        .o_cos   (cos_t),
        .o_sin   (sin_t)
    );

    uvs_cordic u_cordic_phi (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (r_dv[DIV_STAGES].lane[LANE_PHI].quo[TURN_BITS-1:0]),
        .o_cos   (cos_p),
        .o_sin   (sin_p)
    );

    assign rad_s = $signed({1'b0, r_radius});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= n_sd0;
            for (int s = 0; s < CORDIC_LAT - 1; s++) begin
                r_sd[s+1] <= r_sd[s];
            end

            r_m1_px <= cos_t * sin_p;
            r_m1_pz <= sin_t * sin_p;
            r_m1_ny <= cos_p;
            r_m1_sd <= r_sd[CORDIC_LAT-1];

            r_m2_nx <= NORM_W'(rnd_shr(WIDE_W'(r_m1_px), 14));
            r_m2_nz <= NORM_W'(rnd_shr(WIDE_W'(r_m1_pz), 14));
            r_m2_ny <= r_m1_ny;
            r_m2_sd <= r_m1_sd;

            r_m3_qx <= r_m2_nx * rad_s;
            r_m3_qy <= r_m2_ny * rad_s;
            r_m3_qz <= r_m2_nz * rad_s;
            r_m3_nx <= r_m2_nx;
            r_m3_ny <= r_m2_ny;
            r_m3_nz <= r_m2_nz;
            r_m3_sd <= r_m2_sd;

            r_oor <= r_m3_sd.oor;
            if (r_m3_sd.oor) begin
                r_pos_x  <= '0;
                r_pos_y  <= '0;
                r_pos_z  <= '0;
                r_norm_x <= '0;
                r_norm_y <= '0;
                r_norm_z <= '0;
                r_tex_u  <= '0;
                r_tex_v  <= '0;
            end else begin
                r_pos_x  <= POS_W'(rnd_shr(WIDE_W'(r_m3_qx), 14));
                r_pos_y  <= POS_W'(rnd_shr(WIDE_W'(r_m3_qy), 14));
                r_pos_z  <= POS_W'(rnd_shr(WIDE_W'(r_m3_qz), 14));
                r_norm_x <= r_m3_nx;
                r_norm_y <= r_m3_ny;
                r_norm_z <= r_m3_nz;
                r_tex_u  <= r_m3_sd.tex_u;
                r_tex_v  <= r_m3_sd.tex_v;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pos_x        = r_pos_x;
    assign o_pos_y        = r_pos_y;
    assign o_pos_z        = r_pos_z;
    assign o_norm_x       = r_norm_x;
    assign o_norm_y       = r_norm_y;
    assign o_norm_z       = r_norm_z;
    assign o_tex_u        = r_tex_u;
    assign o_tex_v        = r_tex_v;
    assign o_out_of_range = r_oor;

`ifndef NO_ASSERTIONS
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> o_pos_x == 0 && o_pos_y == 0 && o_pos_z == 0
            && o_norm_x == 0 && o_norm_y == 0 && o_norm_z == 0
            && o_tex_u == 0 && o_tex_v == 0)
        else $error("out-of-range beat carries nonzero fields");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seg_count >= COUNT_W'(MIN_SEGMENTS) && r_seg_count <= COUNT_W'(MAX_SEGMENTS)
            && r_ring_count >= COUNT_W'(MIN_RINGS) && r_ring_count <= COUNT_W'(MAX_RINGS))
        else $error("count register outside its range");

    a_norm_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_norm_y <= NORM_W'(Q14_ONE) && o_norm_y >= -NORM_W'(Q14_ONE))
        else $error("normal y exceeds unit length");
`endif

endmodule
